FILE: rtl/upc_pkg.sv
package upc_pkg;

   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam logic [7:0] HEX_DIGIT_OFFSET = 8'd48;
   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'(97 - 10);
   localparam logic [7:0] HEX_UPPER_BASE   = 8'(65 - 10);
   localparam logic [7:0] NIBBLE_HI_MASK   = 8'hF0;
   localparam logic [7:0] NIBBLE_LO_MASK   = 8'h0F;

   typedef enum logic {
      MODE_DECODE = 1'b0,
      MODE_ENCODE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_NONE    = 2'd0,
      PHASE_PERCENT = 2'd1,
      PHASE_DIGIT   = 2'd2
   } phase_type;

   typedef logic [7:0] byte_array_type [MAX_RESULTS];

   function automatic logic is_unreserved(input logic [7:0] c);
      is_unreserved = (c inside {["0":"9"], ["a":"z"], ["A":"Z"], ".", "_", "~", "-"});
   endfunction

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      hex_value = 5'h10;
      if (c inside {["0":"9"]}) begin
         diff = c - HEX_DIGIT_OFFSET;
         hex_value = {1'b0, diff[3:0]};
      end else if (c inside {["a":"f"]}) begin
         diff = c - HEX_ALPHA_OFFSET;
         hex_value = {1'b0, diff[3:0]};
      end else if (c inside {["A":"F"]}) begin
         diff = c - HEX_UPPER_BASE;
         hex_value = {1'b0, diff[3:0]};
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v <= 4'd9) begin
         hex_char = {4'h0, v} + HEX_DIGIT_OFFSET;
      end else begin
         hex_char = {4'h0, v} + HEX_ALPHA_OFFSET;
      end
   endfunction

endpackage

FILE: rtl/url_percent_codec_top.sv
// The first result of a request is registered and appears in the cycle after acceptance.
// Throughput: one result byte per cycle while rsp_tready is high; a request that
// expands to three bytes (an encoded escape) holds off the next request until the
// three-entry result buffer is down to its last byte and that byte is taken.
// Reset: synchronous, active high; clears the mode to decode, the escape state
// and the result buffer.
module url_percent_codec_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast
);

   upc_pkg::mode_type       mode_ff;
   upc_pkg::phase_type      phase_ff;
   upc_pkg::phase_type      phase_in;
   logic [7:0]              held_ff;
   logic [7:0]              held_in;
   upc_pkg::byte_array_type res_ff;
   upc_pkg::byte_array_type res_in;
   logic [1:0]              cnt_ff;
   logic [1:0]              cnt_in;
   logic                    last_ff;

   logic                    req_acc;
   logic                    rsp_pop;
   logic [4:0]              hex_hi;
   logic [4:0]              hex_lo;
   logic                    do_feed;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = res_ff[0];
   assign rsp_tlast  = last_ff && (cnt_ff == 2'd1);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign hex_hi = upc_pkg::hex_value(held_ff);
   assign hex_lo = upc_pkg::hex_value(req_tdata);

   always_comb begin
      res_in   = '{default: 8'h00};
      cnt_in   = 2'd0;
      phase_in = phase_ff;
      held_in  = held_ff;
      do_feed  = 1'b0;
      if (mode_ff == upc_pkg::MODE_ENCODE) begin
         phase_in = upc_pkg::PHASE_NONE;
         if (upc_pkg::is_unreserved(req_tdata)) begin
            res_in[0] = req_tdata;
            cnt_in    = 2'd1;
         end else begin
            res_in[0] = upc_pkg::CHAR_PERCENT;
            res_in[1] = upc_pkg::hex_char(4'((req_tdata & upc_pkg::NIBBLE_HI_MASK) >> 4));
            res_in[2] = upc_pkg::hex_char(4'(req_tdata & upc_pkg::NIBBLE_LO_MASK));
            cnt_in    = 2'd3;
         end
      end else begin
         case (phase_ff)
            upc_pkg::PHASE_DIGIT: begin
               phase_in = upc_pkg::PHASE_NONE;
               if (!hex_hi[4] && !hex_lo[4]) begin
                  res_in[0] = {hex_hi[3:0], hex_lo[3:0]};
                  cnt_in    = 2'd1;
               end else begin
                  res_in[0] = upc_pkg::CHAR_PERCENT;
                  cnt_in    = 2'd1;
                  do_feed   = 1'b1;
                  if (held_ff == upc_pkg::CHAR_PLUS) begin
                     res_in[1] = upc_pkg::CHAR_SPACE;
                     cnt_in    = 2'd2;
                  end else if (held_ff == upc_pkg::CHAR_PERCENT) begin
                     phase_in = upc_pkg::PHASE_PERCENT;
                  end else begin
                     res_in[1] = held_ff;
                     cnt_in    = 2'd2;
                  end
               end
            end
            upc_pkg::PHASE_PERCENT: begin
               do_feed = 1'b1;
            end
            default: begin
               phase_in = upc_pkg::PHASE_NONE;
               do_feed  = 1'b1;
            end
         endcase

         if (do_feed) begin
            if ((phase_in == upc_pkg::PHASE_PERCENT) && !req_tlast) begin
               phase_in = upc_pkg::PHASE_DIGIT;
               held_in  = req_tdata;
            end else begin
               if (phase_in == upc_pkg::PHASE_PERCENT) begin
                  res_in[cnt_in] = upc_pkg::CHAR_PERCENT;
                  cnt_in         = cnt_in + 2'd1;
               end
               phase_in = upc_pkg::PHASE_NONE;
               if (req_tdata == upc_pkg::CHAR_PLUS) begin
                  res_in[cnt_in] = upc_pkg::CHAR_SPACE;
                  cnt_in         = cnt_in + 2'd1;
               end else if ((req_tdata == upc_pkg::CHAR_PERCENT) && !req_tlast) begin
                  phase_in = upc_pkg::PHASE_PERCENT;
               end else begin
                  res_in[cnt_in] = req_tdata;
                  cnt_in         = cnt_in + 2'd1;
               end
            end
         end
      end
      if (req_tlast && (cnt_in != 2'd0)) begin
         phase_in = upc_pkg::PHASE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= upc_pkg::MODE_DECODE;
         phase_ff <= upc_pkg::PHASE_NONE;
         held_ff  <= 8'h00;
         cnt_ff   <= 2'd0;
         last_ff  <= 1'b0;
      end else begin
         if (req_acc) begin
            res_ff   <= res_in;
            cnt_ff   <= cnt_in;
            last_ff  <= req_tlast;
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end else if (rsp_pop) begin
            res_ff[0] <= res_ff[1];
            res_ff[1] <= res_ff[2];
            cnt_ff    <= cnt_ff - 2'd1;
         end
         if (csr_wr_en) begin
            mode_ff  <= upc_pkg::mode_type'(csr_wr_data);
            phase_ff <= upc_pkg::PHASE_NONE;
            held_ff  <= 8'h00;
         end
      end
   end

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> cnt_ff != 2'd0)
      else $error("Final request of a string produced no result.");

   a_last_clears_escape: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast && !csr_wr_en |=> phase_ff == upc_pkg::PHASE_NONE)
      else $error("Escape left pending after the end of a string.");

   a_encode_no_escape: assert property (@(posedge clock) disable iff (reset)
      mode_ff == upc_pkg::MODE_ENCODE |-> phase_ff == upc_pkg::PHASE_NONE)
      else $error("Escape pending while encoding.");
`endif

endmodule

FILE: bench/tb_url_percent_codec_top.sv
`timescale 1ns / 100ps

module tb_url_percent_codec_top;
   import upc_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned BYTE_TARGET   = 420;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_MODE  = 2'd1,
      CMD_DRAIN = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   cmd_type      pending_cmds [$];
   out_byte_type expected_bytes [$];
   logic [7:0]   step_bytes [$];

   mode_type   codec_mode = MODE_DECODE;
   phase_type  esc_phase = PHASE_NONE;
   logic [7:0] esc_held = 8'h00;

   int unsigned err_count = 0;
   int unsigned queued_bytes = 0;
   int unsigned strings_queued = 0;
   int unsigned mode_writes = 0;
   int unsigned decoded_requests = 0;
   int unsigned encoded_requests = 0;
   int unsigned checked_bytes = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned drain_count = 0;
   int unsigned idle_cycles = 0;
   logic        sender_calm = 1'b0;
   logic        receiver_calm = 1'b0;
   logic        next_valid;
   logic        next_wr;
   logic        next_ready;
   out_byte_type head_exp;

   url_percent_codec_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic url_safe(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "." || c == "_" || c == "~" || c == "-";
   endfunction

   // Bit 4 flags a byte that is not a hex digit.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         return {1'b0, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         return {1'b0, 4'(c - "A" + 8'd10)};
      end
      return 5'h10;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] v);
      return (v < 4'd10) ? 8'("0" + v) : 8'("a" + v - 4'd10);
   endfunction

   task automatic take_plain(input logic [7:0] b, input logic last);
      if (b == CHAR_PLUS) begin
         step_bytes.push_back(CHAR_SPACE);
      end else if (b == CHAR_PERCENT) begin
         if (last) begin
            step_bytes.push_back(CHAR_PERCENT);
         end else begin
            esc_phase = PHASE_PERCENT;
         end
      end else begin
         step_bytes.push_back(b);
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      if (esc_phase == PHASE_PERCENT) begin
         if (last) begin
            step_bytes.push_back(CHAR_PERCENT);
            esc_phase = PHASE_NONE;
            take_plain(b, last);
         end else begin
            esc_phase = PHASE_DIGIT;
            esc_held = b;
         end
      end else begin
         esc_phase = PHASE_NONE;
         take_plain(b, last);
      end
   endtask

   task automatic predict_request(input logic [7:0] b, input logic last);
      logic [4:0] hi;
      logic [4:0] lo;
      logic [7:0] first;
      step_bytes.delete();
      if (codec_mode == MODE_ENCODE) begin
         encoded_requests++;
         if (url_safe(b)) begin
            step_bytes.push_back(b);
         end else begin
            step_bytes.push_back(CHAR_PERCENT);
            step_bytes.push_back(hex_ascii(b[7:4]));
            step_bytes.push_back(hex_ascii(b[3:0]));
         end
      end else begin
         decoded_requests++;
         if (esc_phase == PHASE_DIGIT) begin
            hi = nibble_of(esc_held);
            lo = nibble_of(b);
            first = esc_held;
            esc_phase = PHASE_NONE;
            esc_held = 8'h00;
            if (!hi[4] && !lo[4]) begin
               step_bytes.push_back({hi[3:0], lo[3:0]});
            end else begin
               step_bytes.push_back(CHAR_PERCENT);
               take_byte(first, 1'b0);
               take_byte(b, last);
            end
         end else begin
            take_byte(b, last);
         end
      end
      if (last && step_bytes.size() > 0) begin
         esc_phase = PHASE_NONE;
      end
      foreach (step_bytes[i]) begin
         expected_bytes.push_back('{data: step_bytes[i],
                                    last: last && (i == step_bytes.size() - 1)});
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last);
      pending_cmds.push_back('{kind: CMD_BYTE, data: b, last: last});
      queued_bytes++;
      if (last) begin
         strings_queued++;
      end
   endtask

   task automatic queue_drain();
      pending_cmds.push_back('{kind: CMD_DRAIN, data: 8'h00, last: 1'b0});
   endtask

   task automatic queue_mode(input mode_type m);
      queue_drain();
      pending_cmds.push_back('{kind: CMD_MODE, data: {7'd0, m}, last: 1'b0});
   endtask

   function automatic logic [7:0] rand_hex();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'("0" + v);
      end
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] rand_safe();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (!url_safe(c));
      return c;
   endfunction

   task automatic queue_string(input mode_type m);
      logic [7:0]  text [$];
      int unsigned len;
      int unsigned pick;
      len = $urandom_range(1, 10);
      while (text.size() < len) begin
         pick = $urandom_range(0, 99);
         if (m == MODE_ENCODE) begin
            text.push_back(pick < 40 ? rand_safe() : 8'($urandom_range(0, 255)));
         end else if (pick < 45) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(rand_hex());
            text.push_back(rand_hex());
         end else if (pick < 55) begin
            text.push_back(CHAR_PLUS);
         end else if (pick < 63) begin
            text.push_back(CHAR_PERCENT);
         end else if (pick < 72) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(rand_hex());
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (text[i]) begin
         queue_byte(text[i], i == text.size() - 1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_wr = 1'b0;
         if (req_tvalid && req_tready) begin
            predict_request(req_tdata, req_tlast);
            next_valid = 1'b0;
            if ($urandom_range(0, 31) == 0) begin
               sender_calm = !sender_calm;
            end
            send_wait = sender_calm ? 0 : $urandom_range(0, 5);
         end
         if (!next_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_cmds.size() > 0) begin
               case (pending_cmds[0].kind)
                  CMD_BYTE: begin
                     req_tdata <= pending_cmds[0].data;
                     req_tlast <= pending_cmds[0].last;
                     next_valid = 1'b1;
                     void'(pending_cmds.pop_front());
                  end
                  CMD_MODE: begin
                     next_wr = 1'b1;
                     csr_wr_data <= pending_cmds[0].data[0];
                     codec_mode = mode_type'(pending_cmds[0].data[0]);
                     esc_phase = PHASE_NONE;
                     esc_held = 8'h00;
                     mode_writes++;
                     void'(pending_cmds.pop_front());
                  end
                  default: begin
                     if (expected_bytes.size() != 0) begin
                        drain_count = 0;
                     end else if (drain_count < SETTLE_CYCLES) begin
                        drain_count++;
                     end else begin
                        drain_count = 0;
                        void'(pending_cmds.pop_front());
                     end
                  end
               endcase
            end
         end
         req_tvalid <= next_valid;
         csr_wr_en <= next_wr;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         next_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            checked_bytes++;
            if (expected_bytes.size() == 0) begin
               $error("out_byte: no result expected, got %h (out_last %b)", rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               head_exp = expected_bytes.pop_front();
               if (rsp_tdata !== head_exp.data) begin
                  $error("out_byte: expected %h, got %h", head_exp.data, rsp_tdata);
                  err_count++;
               end
               if (rsp_tlast !== head_exp.last) begin
                  $error("out_last: expected %b, got %b", head_exp.last, rsp_tlast);
                  err_count++;
               end
            end
            next_ready = 1'b0;
            if ($urandom_range(0, 31) == 0) begin
               receiver_calm = !receiver_calm;
            end
            recv_wait = receiver_calm ? 0 : $urandom_range(0, 5);
         end
         if (!next_ready) begin
            if (recv_wait > 0) begin
               recv_wait--;
            end else begin
               next_ready = 1'b1;
            end
         end
         rsp_tready <= next_ready;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      mode_type phase_mode;
      int unsigned phase_start;
      int unsigned phase_index;

      // Decode: upper and lower case escapes, plus sign, malformed escapes.
      queue_byte("%", 1'b0); queue_byte("4", 1'b0); queue_byte("1", 1'b0);
      queue_byte("%", 1'b0); queue_byte("f", 1'b0); queue_byte("F", 1'b0);
      queue_byte(CHAR_PLUS, 1'b0);
      queue_byte("%", 1'b0); queue_byte("z", 1'b0); queue_byte("q", 1'b0);
      queue_byte("%", 1'b0); queue_byte("%", 1'b0); queue_byte("4", 1'b0);
      queue_byte("1", 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0);
      // A percent sign too close to the end of the string passes through.
      queue_byte("%", 1'b0); queue_byte("4", 1'b1);
      queue_byte("%", 1'b1);
      // A pending escape is dropped by the mode write that follows.
      queue_byte("%", 1'b0); queue_byte("4", 1'b0);
      queue_mode(MODE_ENCODE);
      queue_byte("A", 1'b0); queue_byte("~", 1'b0); queue_byte(" ", 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b1);

      phase_index = 0;
      while (queued_bytes < BYTE_TARGET) begin
         if (phase_index < 2) begin
            phase_mode = mode_type'(phase_index[0]);
         end else begin
            phase_mode = mode_type'($urandom_range(0, 1));
         end
         queue_mode(phase_mode);
         phase_start = queued_bytes;
         while (queued_bytes - phase_start < 45 && queued_bytes < BYTE_TARGET) begin
            queue_string(phase_mode);
            if ($urandom_range(0, 9) == 0) begin
               queue_drain();
            end
         end
         phase_index++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Sent %0d requests in %0d strings (%0d decoded, %0d encoded) over %0d mode writes.",
               decoded_requests + encoded_requests, strings_queued, decoded_requests,
               encoded_requests, mode_writes);
      $display("Checked %0d result bytes against the prediction.", checked_bytes);
      if (err_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
